### hw/rtl/vwt_pkg.sv
// Package for the vertex weld table.
// Holds the controller state type and the fixed field widths; no dependencies.
package vwt_pkg;

  localparam int unsigned NumComp = 8;
  localparam int unsigned TolW    = 15;
  localparam int unsigned VidxW   = 10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } vwt_state_e;

endpackage

### hw/rtl/vwt_cell.sv
// One cell of the weld table: a bank of stored vertices, a compare row and
// one step of the lowest-match priority chain. Depends on vwt_pkg.
module vwt_cell #(
  parameter int unsigned COMPONENT_BITS = 16,
  parameter int unsigned ROWS           = 128,
  parameter int unsigned RW             = 7,
  parameter int unsigned CW             = 3,
  parameter int unsigned UW             = 11,
  parameter int unsigned CELL_ID        = 0
) (
  input  logic                                              clk_i,
  input  logic                                              rd_en_i,
  input  logic [RW-1:0]                                     rd_row_i,
  input  logic [RW-1:0]                                     cmp_row_i,
  input  logic [UW-1:0]                                     used_i,
  input  logic [vwt_pkg::TolW-1:0]                          tol_i,
  input  logic [vwt_pkg::NumComp-1:0][COMPONENT_BITS-1:0]   vtx_i,
  input  logic                                              wr_en_i,
  input  logic [RW-1:0]                                     wr_row_i,
  input  logic                                              hit_i,
  input  logic [CW-1:0]                                     first_i,
  output logic                                              hit_o,
  output logic [CW-1:0]                                     first_o
);

  localparam int unsigned DiffW = ((COMPONENT_BITS + 1 > vwt_pkg::TolW) ?
                                   COMPONENT_BITS + 1 : vwt_pkg::TolW) + 1;
  localparam int unsigned IxW   = RW + CW;
  localparam int unsigned EcW   = (IxW > UW) ? IxW : UW;

  logic [vwt_pkg::NumComp-1:0][COMPONENT_BITS-1:0] mem [ROWS];
  logic [vwt_pkg::NumComp-1:0][COMPONENT_BITS-1:0] rd_q;
  logic [vwt_pkg::NumComp-1:0]                     near;
  logic [DiffW-1:0]                                diff [vwt_pkg::NumComp];
  logic [DiffW-1:0]                                mag  [vwt_pkg::NumComp];
  logic                                            entry_ok;
  logic                                            match_d;
  logic                                            match_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row_i] <= vtx_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_row_i];
    end
  end

  always_comb begin
    for (int c = 0; c < int'(vwt_pkg::NumComp); c++) begin
      diff[c] = {{(DiffW - COMPONENT_BITS){vtx_i[c][COMPONENT_BITS-1]}}, vtx_i[c]}
              - {{(DiffW - COMPONENT_BITS){rd_q[c][COMPONENT_BITS-1]}}, rd_q[c]};
      mag[c]  = diff[c][DiffW-1] ? (~diff[c] + 1'b1) : diff[c];
      near[c] = mag[c] < DiffW'(tol_i);
    end
    entry_ok = EcW'({cmp_row_i, CW'(CELL_ID)}) < EcW'(used_i);
    match_d  = entry_ok && (&near);
  end

  always_ff @(posedge clk_i) begin
    match_q <= match_d;
  end

  assign hit_o   = hit_i | match_q;
  assign first_o = hit_i ? first_i : CW'(CELL_ID);

endmodule

### hw/rtl/vertex_weld_table.sv
// Vertex weld table: a row of CELL_COUNT cells, each holding one bank of kept vertices.
// Each search reads one bank row per cycle; a match ends the scan early, and an empty table
// needs no row reads. One item at a time: the next word is accepted once the result is loaded
// into the output register, later while a result waits.
// Reset empties the table and clears the tolerance; stored vertices are not cleared.
// Depends on vwt_pkg and vwt_cell. CELL_COUNT must be a power of two, at least 2.
module vertex_weld_table #(
  parameter int unsigned TABLE_DEPTH    = 1024,
  parameter int unsigned COMPONENT_BITS = 16,
  parameter int unsigned CELL_COUNT     = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [vwt_pkg::TolW-1:0]         match_tolerance_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             start_mesh_i,
  input  logic signed [COMPONENT_BITS-1:0] pos_x_i,
  input  logic signed [COMPONENT_BITS-1:0] pos_y_i,
  input  logic signed [COMPONENT_BITS-1:0] pos_z_i,
  input  logic signed [COMPONENT_BITS-1:0] tex_u_i,
  input  logic signed [COMPONENT_BITS-1:0] tex_v_i,
  input  logic signed [COMPONENT_BITS-1:0] norm_x_i,
  input  logic signed [COMPONENT_BITS-1:0] norm_y_i,
  input  logic signed [COMPONENT_BITS-1:0] norm_z_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [vwt_pkg::VidxW-1:0]        vertex_index_o,
  output logic                             is_new_o,
  output logic                             table_full_o
);

  localparam int unsigned ROWS = (TABLE_DEPTH + CELL_COUNT - 1) / CELL_COUNT;
  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CW   = $clog2(CELL_COUNT);
  localparam int unsigned UW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IxW  = RW + CW;

  vwt_pkg::vwt_state_e state_q, state_d;

  logic [vwt_pkg::TolW-1:0]                        tol_q;
  logic [vwt_pkg::NumComp-1:0][COMPONENT_BITS-1:0] vtx_q;
  logic                                            vtx_ld;
  logic [UW-1:0]                                   used_q, used_d;
  logic [RW-1:0]                                   row_q, row_d;
  logic [RW-1:0]                                   last_row_q, last_row_d;
  logic                                            issue_q, issue_d;
  logic                                            p1_valid_q, p1_valid_d;
  logic [RW-1:0]                                   p1_row_q, p1_row_d;
  logic                                            p2_valid_q, p2_valid_d;
  logic [RW-1:0]                                   p2_row_q, p2_row_d;
  logic                                            rd_en;
  logic                                            wr_en;
  logic [RW-1:0]                                   wr_row;
  logic [IxW-1:0]                                  res_idx_q, res_idx_d;
  logic                                            res_new_q, res_new_d;
  logic                                            res_full_q, res_full_d;
  logic                                            out_ld;
  logic                                            out_valid_q;
  logic [IxW+vwt_pkg::VidxW-1:0]                   idx_ext;
  logic [vwt_pkg::VidxW-1:0]                       out_idx_q;
  logic                                            out_new_q;
  logic                                            out_full_q;
  logic [CELL_COUNT:0]                             hit_chain;
  logic [CELL_COUNT:0][CW-1:0]                     first_chain;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != vwt_pkg::ST_IDLE);
  assign wr_row      = RW'(used_q >> CW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= match_tolerance_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vtx_ld) begin
      vtx_q <= {norm_z_i, norm_y_i, norm_x_i, tex_v_i, tex_u_i, pos_z_i, pos_y_i, pos_x_i};
    end
  end

  assign hit_chain[0]   = 1'b0;
  assign first_chain[0] = '0;

  for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
    vwt_cell #(
      .COMPONENT_BITS (COMPONENT_BITS),
      .ROWS           (ROWS),
      .RW             (RW),
      .CW             (CW),
      .UW             (UW),
      .CELL_ID        (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rd_en_i   (rd_en),
      .rd_row_i  (row_q),
      .cmp_row_i (p1_row_q),
      .used_i    (used_q),
      .tol_i     (tol_q),
      .vtx_i     (vtx_q),
      .wr_en_i   (wr_en && (used_q[CW-1:0] == CW'(k))),
      .wr_row_i  (wr_row),
      .hit_i     (hit_chain[k]),
      .first_i   (first_chain[k]),
      .hit_o     (hit_chain[k+1]),
      .first_o   (first_chain[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vwt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    row_d      = row_q;
    last_row_d = last_row_q;
    issue_d    = issue_q;
    p1_valid_d = 1'b0;
    p1_row_d   = row_q;
    p2_valid_d = p1_valid_q;
    p2_row_d   = p1_row_q;
    res_idx_d  = res_idx_q;
    res_new_d  = res_new_q;
    res_full_d = res_full_q;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    vtx_ld     = 1'b0;
    out_ld     = 1'b0;
    case (state_q)
      vwt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          vtx_ld     = 1'b1;
          used_d     = start_mesh_i ? '0 : used_q;
          issue_d    = (used_d != '0);
          row_d      = '0;
          last_row_d = RW'((used_d - 1'b1) >> CW);
          state_d    = vwt_pkg::ST_SEARCH;
        end
      end
      vwt_pkg::ST_SEARCH: begin
        if (issue_q) begin
          rd_en      = 1'b1;
          p1_valid_d = 1'b1;
          if (row_q == last_row_q) begin
            issue_d = 1'b0;
          end else begin
            row_d = row_q + 1'b1;
          end
        end
        if (p2_valid_q && hit_chain[CELL_COUNT]) begin
          res_idx_d  = {p2_row_q, first_chain[CELL_COUNT]};
          res_new_d  = 1'b0;
          res_full_d = 1'b0;
          issue_d    = 1'b0;
          p1_valid_d = 1'b0;
          p2_valid_d = 1'b0;
          state_d    = vwt_pkg::ST_DONE;
        end else if (!issue_q && !p1_valid_q && !p2_valid_q) begin
          if (used_q == UW'(TABLE_DEPTH)) begin
            res_idx_d  = '0;
            res_new_d  = 1'b0;
            res_full_d = 1'b1;
          end else begin
            wr_en      = 1'b1;
            used_d     = used_q + 1'b1;
            res_idx_d  = IxW'(used_q);
            res_new_d  = 1'b1;
            res_full_d = 1'b0;
          end
          state_d = vwt_pkg::ST_DONE;
        end
      end
      vwt_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_ld  = 1'b1;
          state_d = vwt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vwt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      issue_q     <= 1'b0;
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      used_q     <= used_d;
      issue_q    <= issue_d;
      p1_valid_q <= p1_valid_d;
      p2_valid_q <= p2_valid_d;
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign idx_ext = {{vwt_pkg::VidxW{1'b0}}, res_idx_q};

  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    last_row_q <= last_row_d;
    p1_row_q   <= p1_row_d;
    p2_row_q   <= p2_row_d;
    res_idx_q  <= res_idx_d;
    res_new_q  <= res_new_d;
    res_full_q <= res_full_d;
    if (out_ld) begin
      out_idx_q  <= idx_ext[vwt_pkg::VidxW-1:0];
      out_new_q  <= res_new_q;
      out_full_q <= res_full_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign vertex_index_o = out_idx_q;
  assign is_new_o       = out_new_q;
  assign table_full_o   = out_full_q;

  // The entry count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // An accepted vertex blocks the input until its result is produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not held off after accept");

  // Compare results are only in flight during a search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_valid_q || p2_valid_q) |-> (state_q == vwt_pkg::ST_SEARCH))
    else $error("compare pipeline active outside search");

  // A full-table result never claims a new entry and carries index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && table_full_o) |-> (!is_new_o && (vertex_index_o == '0)))
    else $error("inconsistent full-table result");

  // Appending advances the entry count by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (used_q == $past(used_q) + 1'b1))
    else $error("append did not advance entry count");

endmodule
